FILE: rtl/cpmbc_pkg.sv
`timescale 1ns / 1ps
package cpmbc_pkg;

  localparam int unsigned COUNT_WIDTH = 48;
  localparam int unsigned OUT_WIDTH   = 48;
  localparam int unsigned NUM_DRAWS   = 12;
  localparam int unsigned NUM_WARM    = 10;
  localparam int unsigned NUM_HALVES  = 12;

  localparam logic [63:0] SEED_XOR_A = 64'h6A09E667F3BCC909;
  localparam logic [63:0] SEED_XOR_B = 64'hBB67AE8584CAA73B;
  localparam logic [31:0] FLIP_BIT   = 32'h00000040;
  localparam logic [31:0] SIGMA0     = 32'h61707865;
  localparam logic [31:0] SIGMA1     = 32'h3320646e;
  localparam logic [31:0] SIGMA2     = 32'h79622d32;
  localparam logic [31:0] SIGMA3     = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  // one queue entry: the twelve drawn words plus the restart flag
  typedef struct packed {
    logic                  restart;
    logic [11:0][31:0]     words;
  } item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // half of a quarter round: two adds, two xors, two rotates
  function automatic quad_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input logic second);
    quad_t q;
    q.a = a + b;
    q.d = second ? rotl(d ^ q.a, 8) : rotl(d ^ q.a, 16);
    q.c = c + q.d;
    q.b = second ? rotl(b ^ q.c, 7) : rotl(b ^ q.c, 12);
    return q;
  endfunction

  // one half step of a column or diagonal round over the whole state
  function automatic state_t round_half(input state_t w, input logic diag,
                                        input logic second);
    state_t col;
    state_t dg;
    quad_t  q;
    col = w;
    dg  = w;
    for (int i = 0; i < 4; i++) begin
      q = qr_half(w[i], w[4 + i], w[8 + i], w[12 + i], second);
      col[i] = q.a; col[4 + i] = q.b; col[8 + i] = q.c; col[12 + i] = q.d;
      q = qr_half(w[i], w[4 + ((i + 1) % 4)], w[8 + ((i + 2) % 4)],
                  w[12 + ((i + 3) % 4)], second);
      dg[i] = q.a; dg[4 + ((i + 1) % 4)] = q.b;
      dg[8 + ((i + 2) % 4)] = q.c; dg[12 + ((i + 3) % 4)] = q.d;
    end
    return diag ? dg : col;
  endfunction

  // fixed linear plus quadratic mask over the difference
  function automatic logic eval_mask(input state_t d);
    logic r;
    r = d[0][16] ^ d[0][0]
      ^ d[1][23] ^ d[1][12] ^ d[1][11] ^ d[1][7] ^ d[1][0]
      ^ d[2][24] ^ d[2][19] ^ d[2][18] ^ d[2][16] ^ d[2][8] ^ d[2][7] ^ d[2][0]
      ^ d[4][19] ^ d[4][13] ^ d[4][7]
      ^ d[5][7]
      ^ d[6][19] ^ d[6][14] ^ d[6][7]
      ^ d[7][26] ^ d[7][15] ^ d[7][7] ^ d[7][6]
      ^ d[8][31] ^ d[8][19] ^ d[8][8] ^ d[8][0]
      ^ d[9][26] ^ d[9][12] ^ d[9][6] ^ d[9][0]
      ^ d[10][0]
      ^ d[11][7]
      ^ d[12][31] ^ d[12][20] ^ d[12][19] ^ d[12][12] ^ d[12][0]
      ^ d[13][27] ^ d[13][26] ^ d[13][24] ^ d[13][15] ^ d[13][0]
      ^ d[14][26] ^ d[14][8]
      ^ d[15][24];
    r ^= ~d[1][6] & (d[6][13] ^ d[11][6]);
    r ^= ~(d[1][6] ^ d[6][13] ^ d[11][6]) & ~d[1][5] & (d[6][12] ^ d[11][5]);
    r ^= ~d[11][11] & d[12][11];
    r ^= ~(d[11][11] ^ d[12][11]) & ~d[11][10] & d[12][10];
    r ^= ~d[2][7] & (d[7][14] ^ d[8][7]);
    r ^= ~(d[2][7] ^ d[7][14] ^ d[8][7]) & ~d[2][6] & (d[7][13] ^ d[8][6]);
    r ^= ~d[9][25] & d[14][25];
    r ^= ~(d[9][25] ^ d[14][25]) & ~d[9][24] & d[14][24];
    return r;
  endfunction

endpackage

FILE: rtl/cpmbc_if.sv
`timescale 1ns / 1ps
interface cpmbc_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cpmbc_res_if;
  logic        valid;
  logic        ready;
  logic        mask_bit;
  logic [47:0] zeros_so_far;
  logic [47:0] samples_so_far;
  modport source (output valid, output mask_bit, output zeros_so_far,
                  output samples_so_far, input ready);
  modport sink   (input valid, input mask_bit, input zeros_so_far,
                  input samples_so_far, output ready);
endinterface

FILE: rtl/chacha_pair_mask_bias_counter.sv
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// req_i   | in  | valid / ready       | restart
// res_o   | out | valid / ready       | mask_bit, zeros_so_far, samples_so_far
// cfg     | in  | cfg_we_i            | cfg_wdata_i (seed)
//
// A transaction costs 12 generator draws at one per cycle in the front end
// (the last draw waits while the queue is full), plus 10 warm-up draws on
// restart; the round engine runs 12 half rounds and one mask step per
// sample, finishing one before it loads the next. A two-entry queue lets the
// front keep drawing while engine or output stalls; async active-low reset.
module chacha_pair_mask_bias_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  cpmbc_req_if.sink   req_i,
  cpmbc_res_if.source res_o
);

  logic [63:0]      seed_q;
  logic             push, full, pop, qvalid;
  cpmbc_pkg::item_t push_item, pop_item;

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_we_i) seed_q <= cfg_wdata_i;
  end

  cpmbc_front u_front (
    .clk_i, .rst_ni, .seed_i(seed_q), .req_i,
    .full_i(full), .push_o(push), .item_o(push_item)
  );

  cpmbc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_item), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .data_o(pop_item)
  );

  cpmbc_back u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .item_i(pop_item), .pop_o(pop), .res_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qvalid) else $error("queue read while empty");
  a_zeros_le_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.zeros_so_far <= res_o.samples_so_far))
    else $error("zero count exceeds sample count");

endmodule

FILE: rtl/cpmbc_front.sv
`timescale 1ns / 1ps
module cpmbc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        seed_i,
  cpmbc_req_if.sink          req_i,
  input  logic               full_i,
  output logic               push_o,
  output cpmbc_pkg::item_t   item_o
);

  typedef enum logic [1:0] {F_IDLE, F_WARM, F_DRAW} fstate_e;

  fstate_e          st_q;
  logic [3:0]       cnt_q;
  logic [63:0]      a_q, b_q;
  logic             rflag_q;
  logic [11:0][31:0] buf_q;

  logic        last, draw_en, accept;
  logic [63:0] x, nb;
  logic [31:0] word;

  // xorshift128+ step
  always_comb begin
    x    = a_q ^ (a_q << 23);
    nb   = x ^ b_q ^ (x >> 17) ^ (b_q >> 26);
    word = nb[31:0] + b_q[31:0];
  end

  assign last    = (cnt_q == 4'(cpmbc_pkg::NUM_DRAWS - 1));
  assign draw_en = (st_q == F_WARM) || ((st_q == F_DRAW) && !(last && full_i));
  assign push_o  = (st_q == F_DRAW) && last && !full_i;
  assign req_i.ready = (st_q == F_IDLE) || push_o;
  assign accept  = req_i.valid && req_i.ready;

  // entry carries the current draw as word 11
  always_comb begin
    item_o.restart = rflag_q;
    item_o.words   = buf_q;
    item_o.words[11] = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      cnt_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      rflag_q <= 1'b0;
    end else begin
      if (draw_en) begin
        a_q <= b_q;
        b_q <= nb;
      end
      case (st_q)
        F_WARM: begin
          if (cnt_q == 4'(cpmbc_pkg::NUM_WARM - 1)) begin
            st_q  <= F_DRAW;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        F_DRAW: begin
          if (draw_en) begin
            cnt_q <= cnt_q + 4'd1;
            if (last) st_q <= F_IDLE;
          end
        end
        default: ;
      endcase
      // a new transaction overrides the end of the previous one
      if (accept) begin
        rflag_q <= req_i.restart;
        cnt_q   <= '0;
        if (req_i.restart) begin
          a_q  <= seed_i ^ cpmbc_pkg::SEED_XOR_A;
          b_q  <= seed_i ^ cpmbc_pkg::SEED_XOR_B;
          st_q <= F_WARM;
        end else begin
          st_q <= F_DRAW;
        end
      end
    end
  end

  // word buffer, no reset needed
  always_ff @(posedge clk_i) begin
    if ((st_q == F_DRAW) && draw_en && !last) buf_q[cnt_q] <= word;
  end

endmodule

FILE: rtl/cpmbc_fifo.sv
`timescale 1ns / 1ps
module cpmbc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpmbc_pkg::item_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cpmbc_pkg::item_t data_o
);

  cpmbc_pkg::item_t mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: rtl/cpmbc_back.sv
`timescale 1ns / 1ps
module cpmbc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cpmbc_pkg::item_t item_i,
  output logic             pop_o,
  cpmbc_res_if.source      res_o
);

  localparam logic [cpmbc_pkg::COUNT_WIDTH-1:0] CMAX = '1;

  cpmbc_pkg::state_t x_q, y_q, xi, yi;
  logic       busy_q, rflag_q, ov_q;
  logic [3:0] step_q;
  logic       finish, load, m;
  logic [cpmbc_pkg::COUNT_WIDTH-1:0] samp_q, zero_q, sb, zb, sn, zn;
  logic       mask_q;

  assign finish = busy_q && (step_q == 4'(cpmbc_pkg::NUM_HALVES))
                  && (!ov_q || res_o.ready);
  assign load   = valid_i && (!busy_q || finish);
  assign pop_o  = load;

  // initial states from the queue entry
  always_comb begin
    xi[0] = cpmbc_pkg::SIGMA0;
    xi[1] = cpmbc_pkg::SIGMA1;
    xi[2] = cpmbc_pkg::SIGMA2;
    xi[3] = cpmbc_pkg::SIGMA3;
    for (int i = 0; i < 12; i++) xi[4 + i] = item_i.words[i];
    yi = xi;
    yi[14] = xi[14] ^ cpmbc_pkg::FLIP_BIT;
  end

  // mask and saturating counts
  always_comb begin
    m  = cpmbc_pkg::eval_mask(x_q ^ y_q);
    sb = rflag_q ? '0 : samp_q;
    zb = rflag_q ? '0 : zero_q;
    sn = (sb == CMAX) ? sb : sb + 1'b1;
    zn = (!m && (zb != CMAX)) ? zb + 1'b1 : zb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      ov_q   <= 1'b0;
      samp_q <= '0;
      zero_q <= '0;
    end else begin
      if (res_o.ready) ov_q <= 1'b0;
      if (finish) begin
        ov_q   <= 1'b1;
        samp_q <= sn;
        zero_q <= zn;
        busy_q <= 1'b0;
      end
      if (busy_q && (step_q != 4'(cpmbc_pkg::NUM_HALVES))) step_q <= step_q + 4'd1;
      if (load) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end
  end

  // datapath: one half round per cycle on both states
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q     <= xi;
      y_q     <= yi;
      rflag_q <= item_i.restart;
    end else if (busy_q && (step_q != 4'(cpmbc_pkg::NUM_HALVES))) begin
      x_q <= cpmbc_pkg::round_half(x_q, step_q[1], step_q[0]);
      y_q <= cpmbc_pkg::round_half(y_q, step_q[1], step_q[0]);
    end
    if (finish) mask_q <= m;
  end

  assign res_o.valid          = ov_q;
  assign res_o.mask_bit       = mask_q;
  assign res_o.zeros_so_far   = zero_q[cpmbc_pkg::OUT_WIDTH-1:0];
  assign res_o.samples_so_far = samp_q[cpmbc_pkg::OUT_WIDTH-1:0];

endmodule
